>>> rtl/dpr_pkg.sv
// shared constants and types for the delta pagerank scatter/apply core
package dpr_pkg;

    localparam int VERTICES_DEF      = 1024;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int WEIGHT_BITS       = 16;
    localparam int VIDX_W            = 10;
    localparam int WEIGHT_W          = 17;
    localparam int VAL_W             = 32;
    localparam int COUNT_W           = 11;
    localparam int DAMP_W            = 17;
    localparam logic [DAMP_W-1:0] DAMPING_RESET = 17'd55706;
    localparam logic [VAL_W-1:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_EDGE  = 2'd1;
    localparam logic [1:0] CMD_APPLY = 2'd2;

    localparam logic [0:0] REG_DAMPING   = 1'd0;
    localparam logic [0:0] REG_THRESHOLD = 1'd1;

    // classified operation handed from front to back
    typedef struct packed {
        logic [1:0]        cmd;
        logic [VIDX_W-1:0] vertex;
        logic [VIDX_W-1:0] dest;
        logic [WEIGHT_W-1:0] weight;
        logic [VAL_W-1:0]  rank;
        logic [VAL_W-1:0]  delta;
        logic              active;
        logic              master;
        logic              pass_start;
    } op_t;

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? SAT32 : s[VAL_W-1:0];
    endfunction

endpackage

>>> rtl/dpr_front.sv
// front end: accepts items, drops invalid ones, queues the rest
module dpr_front #(
    parameter int VERTICES = dpr_pkg::VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  dpr_pkg::op_t                in_op,
    output logic                        q_valid,
    input  logic                        q_pop,
    output dpr_pkg::op_t                q_op
);
    localparam int DEPTH = 4;

    dpr_pkg::op_t     mem_reg [DEPTH];
    logic [1:0]       wp_reg, rp_reg;
    logic [2:0]       cnt_reg;
    logic             keep;
    logic             push;

    always_comb
    begin
        keep = (in_op.cmd == dpr_pkg::CMD_LOAD) || (in_op.cmd == dpr_pkg::CMD_EDGE)
               || (in_op.cmd == dpr_pkg::CMD_APPLY);
        keep = keep && (32'(in_op.vertex) < VERTICES);
        if (in_op.cmd == dpr_pkg::CMD_EDGE && !(32'(in_op.dest) < VERTICES))
            keep = 1'b0;
    end

    assign in_stall = (cnt_reg == 3'(DEPTH));
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_op     = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (q_pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(q_pop);
        end
    end
endmodule

>>> rtl/dpr_ram.sv
// generic ram with separate write and read ports, registered read
module dpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/dpr_back.sv
// back end: sequencer doing the table reads, arithmetic and write-back
module dpr_back #(
    parameter int VERTICES = dpr_pkg::VERTICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  dpr_pkg::op_t                      q_op,
    input  logic [dpr_pkg::DAMP_W-1:0]        damping,
    input  logic [dpr_pkg::VAL_W-1:0]         threshold,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dpr_pkg::VIDX_W-1:0]        out_vertex,
    output logic [dpr_pkg::VAL_W-1:0]         new_rank,
    output logic [dpr_pkg::VAL_W-1:0]         new_delta,
    output logic                              now_active,
    output logic [dpr_pkg::COUNT_W-1:0]       active_total
);
    localparam int AW = $clog2(VERTICES);
    localparam int VW = dpr_pkg::VAL_W;
    localparam int CW = dpr_pkg::COUNT_W;
    localparam int MW = VW + 1;  // message ram word: valid, sum
    localparam int GW = 2;       // flag ram word: master, active

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MUL1, S_MUL2, S_WRITE, S_OUT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_reg;
    dpr_pkg::op_t      op_reg;
    logic [VW-1:0]     rank_rd, delta_rd;
    logic [MW-1:0]     msg_rd;
    logic [GW-1:0]     flag_rd;
    logic              flag_act_rd, flag_mst_rd, msg_ok_rd;
    logic [VW-1:0]     msg_val_rd;
    logic [VW:0]       p_reg;
    logic [VW-1:0]     m_reg;

    logic [AW-1:0] a_v, a_d;
    logic          we_rank, we_delta, we_flag, we_msg;
    logic [AW-1:0] wa_flag, wa_msg;
    logic [VW-1:0] wd_rank, wd_delta;
    logic [GW-1:0] wd_flag;
    logic [MW-1:0] wd_msg;
    logic [AW-1:0] ra_msg;

    logic               ovalid_reg;
    logic [dpr_pkg::VIDX_W-1:0] ovtx_reg;
    logic [VW-1:0]      orank_reg, odelta_reg;
    logic               oact_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_base, cnt_next;
    logic [48:0]        prod1;
    logic [49:0]        prod2;
    logic [VW-1:0]      msum;
    logic [VW-1:0]      rank_sum;
    logic               hit;
    logic               fire;

    assign a_v = AW'(op_reg.vertex);
    assign a_d = AW'(op_reg.dest);
    assign flag_mst_rd = flag_rd[1];
    assign flag_act_rd = flag_rd[0];
    assign msg_ok_rd   = msg_rd[VW];
    assign msg_val_rd  = msg_rd[VW-1:0];
    assign ra_msg = (op_reg.cmd == dpr_pkg::CMD_EDGE) ? a_d : a_v;

    dpr_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_rank (
        .clk(clk), .we(we_rank), .waddr(a_v), .wdata(wd_rank),
        .raddr(a_v), .rdata(rank_rd));
    dpr_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_delta (
        .clk(clk), .we(we_delta), .waddr(a_v), .wdata(wd_delta),
        .raddr(a_v), .rdata(delta_rd));
    dpr_ram #(.WIDTH(GW), .DEPTH(VERTICES)) u_flag (
        .clk(clk), .we(we_flag), .waddr(wa_flag), .wdata(wd_flag),
        .raddr(a_v), .rdata(flag_rd));
    dpr_ram #(.WIDTH(MW), .DEPTH(VERTICES)) u_msg (
        .clk(clk), .we(we_msg), .waddr(wa_msg), .wdata(wd_msg),
        .raddr(ra_msg), .rdata(msg_rd));

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // a register sits after each product; the first one keeps 33 bits
    assign prod1 = 49'(delta_rd) * 49'(op_reg.weight);
    assign prod2 = 50'(p_reg) * 50'(damping);
    assign msum  = dpr_pkg::sat_add(msg_ok_rd ? msg_val_rd : '0, m_reg);

    assign rank_sum = dpr_pkg::sat_add(rank_rd, msg_val_rd);
    assign hit      = flag_mst_rd && msg_ok_rd;
    // table writes of an apply wait for the output slot, so reads stay stable
    assign fire     = (state_reg == S_OUT) && (!ovalid_reg || !out_stall);
    assign cnt_base = op_reg.pass_start ? '0 : cnt_reg;
    assign cnt_next = (hit && cnt_base != dpr_pkg::COUNT_MAX) ? cnt_base + CW'(1) : cnt_base;

    always_comb
    begin
        we_rank  = 1'b0;
        we_delta = 1'b0;
        we_flag  = 1'b0;
        we_msg   = 1'b0;
        wd_rank  = op_reg.rank;
        wd_delta = op_reg.delta;
        wa_flag  = a_v;
        wd_flag  = {op_reg.master, op_reg.active};
        wa_msg   = a_d;
        wd_msg   = {1'b1, msum};
        unique case (state_reg)
            S_CLEAR:
            begin
                we_flag = 1'b1;
                wa_flag = clr_reg;
                wd_flag = '0;
                we_msg  = 1'b1;
                wa_msg  = clr_reg;
                wd_msg  = '0;
            end
            S_READ:
            begin
                if (op_reg.cmd == dpr_pkg::CMD_LOAD)
                begin
                    we_rank  = 1'b1;
                    we_delta = 1'b1;
                    we_flag  = 1'b1;
                    we_msg   = 1'b1;
                    wa_msg   = a_v;
                    wd_msg   = '0;
                end
            end
            S_WRITE:
                we_msg = 1'b1;
            S_OUT:
            begin
                if (fire)
                begin
                    we_flag  = 1'b1;
                    wd_flag  = {flag_mst_rd, hit};
                    we_msg   = 1'b1;
                    wa_msg   = a_v;
                    wd_msg   = '0;
                    we_rank  = hit;
                    wd_rank  = rank_sum;
                    we_delta = hit;
                    wd_delta = msg_val_rd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            op_reg <= q_op;
        if (state_reg == S_MUL1)
            p_reg <= prod1[48:16];
        if (state_reg == S_MUL2)
            m_reg <= (|prod2[49:48]) ? dpr_pkg::SAT32 : prod2[47:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            ovtx_reg   <= '0;
            orank_reg  <= '0;
            odelta_reg <= '0;
            oact_reg   <= 1'b0;
        end
        else
        begin
            ovalid_reg <= fire || (ovalid_reg && out_stall);
            if (fire)
            begin
                cnt_reg    <= cnt_next;
                ovtx_reg   <= op_reg.vertex;
                orank_reg  <= hit ? rank_sum : rank_rd;
                odelta_reg <= hit ? msg_val_rd : delta_rd;
                oact_reg   <= hit;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    // zero flag and message tables once after reset
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(VERTICES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    unique case (op_reg.cmd)
                        dpr_pkg::CMD_LOAD:
                            state_reg <= S_IDLE;
                        dpr_pkg::CMD_EDGE:
                            state_reg <= S_MUL1;
                        default:
                            state_reg <= S_OUT;
                    endcase
                end
                S_MUL1:
                begin
                    // delta read is valid now; gate on source activity and delta above threshold
                    if (flag_act_rd && delta_rd > threshold)
                        state_reg <= S_MUL2;
                    else
                        state_reg <= S_IDLE;
                end
                S_MUL2:
                    state_reg <= S_WRITE;
                S_WRITE:
                    state_reg <= S_IDLE;
                S_OUT:
                begin
                    if (fire)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_vertex   = ovtx_reg;
    assign new_rank     = orank_reg;
    assign new_delta    = odelta_reg;
    assign now_active   = oact_reg;
    assign active_total = cnt_reg;
endmodule

>>> rtl/delta_pagerank_scatter_apply_core.sv
// delta pagerank scatter/apply core top level
// back end: apply runs READ, OUT, then the output register; load writes in READ;
// edge runs READ, MUL1, then MUL2 and WRITE unless no scatter; dropped items never
// reach it; it returns to IDLE after each item before popping another, and an apply
// waits in OUT on output stall; a 4-beat queue in front stalls the input when full;
// reset: queue, counter and output clear at once, then a pass over VERTICES entries
// zeroes flag and message tables; rank/delta stay unwritten; damping 0.85, threshold 0.001
module delta_pagerank_scatter_apply_core #(
    parameter int VERTICES      = dpr_pkg::VERTICES_DEF,
    parameter int FRACTION_BITS = dpr_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [9:0]  vertex_index,
    input  logic [9:0]  dest_index,
    input  logic [16:0] edge_weight,
    input  logic [31:0] rank_value,
    input  logic [31:0] delta_value,
    input  logic        active_flag,
    input  logic        master_flag,
    input  logic        pass_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  out_vertex,
    output logic [31:0] new_rank,
    output logic [31:0] new_delta,
    output logic        now_active,
    output logic [10:0] active_total
);
    localparam logic [31:0] THRESH_RESET =
        32'((((64'd1) << FRACTION_BITS) + 64'd500) / 64'd1000);

    logic [16:0]  damp_reg;
    logic [31:0]  thr_reg;
    dpr_pkg::op_t in_op, q_op;
    logic         q_valid, q_pop;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_reg <= dpr_pkg::DAMPING_RESET;
            thr_reg  <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            unique case (paddr[2:2])
                dpr_pkg::REG_DAMPING:   damp_reg <= pwdata[16:0];
                dpr_pkg::REG_THRESHOLD: thr_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2:2])
            dpr_pkg::REG_DAMPING:   prdata = {15'd0, damp_reg};
            default:                prdata = thr_reg;
        endcase
    end

    assign in_op = '{cmd: cmd, vertex: vertex_index, dest: dest_index,
                     weight: edge_weight, rank: rank_value, delta: delta_value,
                     active: active_flag, master: master_flag,
                     pass_start: pass_start};

    dpr_front #(.VERTICES(VERTICES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_op(in_op), .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op));

    dpr_back #(.VERTICES(VERTICES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op),
        .damping(damp_reg), .threshold(thr_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_vertex(out_vertex),
        .new_rank(new_rank), .new_delta(new_delta), .now_active(now_active),
        .active_total(active_total));
endmodule
